### design/cfwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card frame whitelist matcher - shared package
// Constants, the parser-to-matcher queue entry and the header byte lookup.
// ----------------------------------------------------------------------------
package cfwm_pkg;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 8;
   localparam int PAYLOAD_LEN_DEF = 16;

   // Frame layout
   localparam int          HDR_LEN      = 5;
   localparam int          ID_BYTES     = 8;
   localparam logic [7:0]  DOOR_OPEN    = 8'h01;
   localparam logic [3:0]  MAX_ENT_RST  = 4'd2;
   localparam int          QUEUE_DEPTH  = 2;

   // Entry passed from the parser to the matcher.
   // is_door = 1: data[7:0] is a new door state; else data is a card id.
   typedef struct packed {
      logic        is_door;
      logic [63:0] data;
   } qentry_type;

   // Expected header byte for a given header stage
   function automatic logic [7:0] hdr_byte(input logic [2:0] stage);
      logic [7:0] val;
      unique case (stage)
         3'd0:    val = 8'h0A;
         3'd1:    val = 8'h41;
         3'd2:    val = 8'h31;
         3'd3:    val = 8'h46;
         3'd4:    val = 8'h30;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### design/cfwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfwm_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cfwm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card frame parser
// Tracks the header, collects payload bytes, builds the card id and pushes
// frame ids and door writes into the queue in arrival order.
// ----------------------------------------------------------------------------
module cfwm_front #(
   parameter int PAYLOAD_LEN = cfwm_pkg::PAYLOAD_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,
   input  logic                 req_tuser,
   output logic                 push_valid,
   input  logic                 push_ready,
   output cfwm_pkg::qentry_type push_entry
);
   import cfwm_pkg::*;

   localparam int BC_W = $clog2(PAYLOAD_LEN + 1);

   logic [2:0]      stage_ff, stage_in;
   logic [BC_W-1:0] count_ff, count_in;
   logic [7:0]      payload_ff [ID_BYTES];
   logic [7:0]      payload_in [ID_BYTES];
   logic            accept;
   logic            in_payload;
   logic            last_byte;
   logic [7:0]      rx_byte;
   logic [7:0]      door_value;
   logic [63:0]     card_id;

   assign rx_byte    = req_tdata[7:0];
   assign door_value = req_tdata[15:8];
   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign in_payload = (stage_ff == 3'(HDR_LEN));
   assign last_byte  = in_payload && (count_ff == BC_W'(PAYLOAD_LEN - 1));

   // Payload capture with bypass so the id sees the byte taken this cycle
   always_comb begin
      for (int i = 0; i < ID_BYTES; i++) begin
         payload_in[i] = payload_ff[i];
         if (accept && !req_tuser && in_payload && (count_ff == BC_W'(i))) begin
            payload_in[i] = rx_byte;
         end
      end
   end

   // Pairwise reorder: bytes 6,7,4,5,2,3,0,1, first one highest
   assign card_id = {payload_in[6], payload_in[7], payload_in[4], payload_in[5],
                     payload_in[2], payload_in[3], payload_in[0], payload_in[1]};

   // Header and byte count tracking
   always_comb begin
      stage_in = stage_ff;
      count_in = count_ff;
      if (accept && !req_tuser) begin
         if (!in_payload) begin
            if (rx_byte == hdr_byte(stage_ff)) begin
               stage_in = stage_ff + 3'd1;
            end else begin
               stage_in = '0;
               count_in = '0;
            end
         end else if (last_byte) begin
            stage_in = '0;
            count_in = '0;
         end else begin
            count_in = count_ff + BC_W'(1);
         end
      end
   end

   // Queue push: door writes and completed frames
   always_comb begin
      push_valid         = 1'b0;
      push_entry.is_door = req_tuser;
      push_entry.data    = card_id;
      if (req_tuser) begin
         push_entry.data = {56'd0, door_value};
      end
      if (req_tvalid && (req_tuser || last_byte)) begin
         push_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         count_ff <= '0;
      end else begin
         stage_ff <= stage_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ID_BYTES; i++) begin
         payload_ff[i] <= payload_in[i];
      end
   end

endmodule

### design/cfwm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser-to-matcher queue
// Short register FIFO that decouples the parser from the table scan.
// ----------------------------------------------------------------------------
module cfwm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  cfwm_pkg::qentry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cfwm_pkg::qentry_type pop_entry
);
   import cfwm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   qentry_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/cfwm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whitelist matcher
// Scans the id table one entry at a time, enrolls unknown ids while
// there is room, keeps the door register and drives the result register.
// ----------------------------------------------------------------------------
module cfwm_back #(
   parameter int TABLE_DEPTH = cfwm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [3:0]           csr_wr_data,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  cfwm_pkg::qentry_type pop_entry,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser
);
   import cfwm_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;
   localparam int SAT    = (TABLE_DEPTH > 15) ? 15 : TABLE_DEPTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [3:0]        max_ff, max_in;
   logic [CNT_W-1:0]  entries_ff, entries_in;
   logic [7:0]        door_ff, door_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [63:0]       id_ff, id_in;
   logic              known_ff, known_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [71:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;
   logic              out_free;
   logic              has_room;
   logic              enroll;
   logic              ram_rd_en;
   logic [63:0]       ram_rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign has_room = (CMP_W'(entries_ff) < CMP_W'(max_ff))
                  && (entries_ff < CNT_W'(TABLE_DEPTH));
   assign enroll   = (state_ff == ST_DONE) && out_free && !known_ff && has_room;
   assign ram_rd_en = (state_ff == ST_READ);

   // Limit register, saturated at the table depth or 15, whichever is smaller
   always_comb begin
      max_in = max_ff;
      if (csr_wr_en) begin
         max_in = (csr_wr_data >= 4'(SAT)) ? 4'(SAT) : csr_wr_data;
      end
   end

   // Scan sequencer
   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      door_in      = door_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      known_in     = known_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      pop_ready    = 1'b0;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (pop_entry.is_door) begin
                  door_in = pop_entry.data[7:0];
               end else begin
                  id_in    = pop_entry.data;
                  known_in = 1'b0;
                  idx_in   = '0;
                  state_in = (entries_ff == '0) ? ST_DONE : ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (ram_rd_data == id_ff) begin
               known_in = 1'b1;
            end
            if ((CNT_W'(idx_ff) + CNT_W'(1)) == entries_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (known_ff) begin
                  door_in = door_ff | DOOR_OPEN;
               end
               if (enroll) begin
                  entries_in = entries_ff + CNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(known_ff ? (door_ff | DOOR_OPEN) : door_ff), id_ff};
               rsp_user_in  = {enroll, known_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= MAX_ENT_RST;
         entries_ff   <= '0;
         door_ff      <= '0;
         known_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         entries_ff   <= entries_in;
         door_ff      <= door_in;
         known_ff     <= known_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Enrolled id table
   cfwm_ram #(
      .WIDTH (64),
      .DEPTH (TABLE_DEPTH)
   ) u_id_table (
      .clock   (clock),
      .wr_en   (enroll),
      .wr_addr (entries_ff[ADDR_W-1:0]),
      .wr_data (id_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### design/card_frame_whitelist_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card frame whitelist matcher - top level
// Parses card reader frames, matches the card id against enrolled ids,
// enrolls new ids while there is room and opens the door on a match.
// ----------------------------------------------------------------------------
// Usage:
//  req_*: one transaction per reader byte (tuser = 0) or door write
//   (tuser = 1). A frame is header 0A 41 31 46 30 plus PAYLOAD_LEN bytes.
//  rsp_*: one transaction per completed frame with the card id, known and
//   enrolled flags and the resulting door state. Door writes and partial
//   frames give no transaction.
//  csr_*: writes the enrollment limit (saturated at TABLE_DEPTH, at most 15);
//   write only while the block is idle.
// Timing: the parser takes one byte per cycle while the queue has room. The
//  matcher reads the id table RAM one entry at a time (address, then compare)
//  and then registers the frame result. A frame is at least 5 + PAYLOAD_LEN
//  bytes.
// Stalls: a two-entry queue sits between parser and matcher; with rsp_tready
//  low the result register holds, the matcher waits and req_tready drops once
//  the queue fills. Reset clears the parser, entry count and door; the limit
//  returns to 2. No clearing pass is needed.
// ----------------------------------------------------------------------------
module card_frame_whitelist_matcher #(
   parameter int TABLE_DEPTH = cfwm_pkg::TABLE_DEPTH_DEF,
   parameter int PAYLOAD_LEN = cfwm_pkg::PAYLOAD_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte [7:0], door_value [15:8]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // card_id [63:0], door_state [71:64]
   output logic [1:0]  rsp_tuser,   // known [0], enrolled [1]
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data  // max_entries
);
   import cfwm_pkg::*;

   logic       push_valid;
   logic       push_ready;
   qentry_type push_entry;
   logic       pop_valid;
   logic       pop_ready;
   qentry_type pop_entry;

   cfwm_front #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   cfwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   cfwm_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card frame whitelist matcher - testbench
// Drives reader bytes and door writes with random gaps, stalls the result
// side at random, predicts each frame result in a local model of the parser,
// id table and door register, and checks every result transaction in order.
// A short scripted sequence comes first, then randomized frames, broken
// headers, noise and door writes under a range of enrollment limits.
// ----------------------------------------------------------------------------
module tb_top;
   import cfwm_pkg::*;

   localparam int TBL_DEPTH   = 8;
   localparam int PAY_LEN     = 16;
   localparam int DRAIN_WAIT  = 30;    // covers a full matcher scan of TBL_DEPTH entries
   localparam int PHASE_LOAD  = 185;   // frame bytes and door writes per phase
   localparam int MAX_REPORTS = 10;
   localparam int NUM_PHASES  = 6;
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_DOOR = 1'b1;
   localparam logic NO_CHK    = 1'b0;
   localparam logic CHK       = 1'b1;
   localparam logic [39:0] HDR_SEQ = 40'h0A_41_31_46_30;

   typedef struct packed {
      logic [63:0] card_id;
      logic        known;
      logic        enrolled;
      logic [7:0]  door_state;
   } frame_res_type;

   // Scripted frame: payload 01..08 swapped pairwise, door left at FF
   localparam frame_res_type SCRIPT_RES = {64'h0708_0506_0304_0102, 1'b0, 1'b1, 8'hFF};

   // DUT signals
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [15:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Model state
   logic [2:0]  hdr_stage;
   int unsigned pay_cnt;
   logic [7:0]  pay_buf [ID_BYTES];
   logic [63:0] id_tbl [TBL_DEPTH];
   int unsigned n_ids;
   logic [7:0]  door_q;
   logic [3:0]  limit_q;

   frame_res_type pending_frames [$];
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int          errors     = 0;
   int          n_items    = 0;
   int          n_doors    = 0;
   int          n_results  = 0;
   int          n_known    = 0;
   int          n_enrolled = 0;
   int          n_refused  = 0;

   // Scripted rows: {check, func, door_value, rx_byte}
   logic [17:0] script [27] = '{
      {NO_CHK, FUNC_DOOR, 8'h00, 8'hA5}, {NO_CHK, FUNC_DOOR, 8'hFF, 8'h5A},
      // header broken by 0A at stage two, then a stray 41 at stage zero
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h0A}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h41},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h0A}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h41},
      // full frame
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h0A}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h41},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h31}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h46},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h30},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h01}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h02},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h03}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h04},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h05}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h06},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h07}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h08},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'hFF}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h00},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'hFF}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h00},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h0A}, {NO_CHK, FUNC_BYTE, 8'h00, 8'h41},
      {NO_CHK, FUNC_BYTE, 8'h00, 8'h31}, {CHK,    FUNC_BYTE, 8'h00, 8'h30}
   };

   logic [3:0] phase_limit [NUM_PHASES] = '{4'd2, 4'd0, 4'd15, 4'd3, 4'd9, 4'd8};

   card_frame_whitelist_matcher uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model of parser, id table and door for one accepted transaction
   task automatic track_reader_item(input logic f, input logic [7:0] rx,
                                    input logic [7:0] dv, output bit has_res,
                                    output frame_res_type res);
      logic [63:0] id;
      bit          hit;
      has_res = 1'b0;
      res     = '0;
      if (f == FUNC_DOOR) begin
         door_q = dv;
      end else if (hdr_stage < HDR_LEN) begin
         // a mismatching byte never starts a new header
         if (rx == HDR_SEQ[39 - 8 * int'(hdr_stage) -: 8]) begin
            hdr_stage++;
         end else begin
            hdr_stage = '0;
            pay_cnt   = 0;
         end
      end else begin
         if (pay_cnt < ID_BYTES) pay_buf[pay_cnt] = rx;
         pay_cnt++;
         if (pay_cnt == PAY_LEN) begin
            // pairs taken from the top: 6,7 then 4,5 then 2,3 then 0,1
            id = {pay_buf[6], pay_buf[7], pay_buf[4], pay_buf[5],
                  pay_buf[2], pay_buf[3], pay_buf[0], pay_buf[1]};
            hit = 1'b0;
            for (int i = 0; i < n_ids; i++) begin
               if (id_tbl[i] == id) hit = 1'b1;
            end
            res.card_id  = id;
            res.known    = hit;
            res.enrolled = 1'b0;
            if (hit) begin
               door_q |= DOOR_OPEN;
            end else if (n_ids < limit_q) begin
               id_tbl[n_ids] = id;
               n_ids++;
               res.enrolled = 1'b1;
            end
            res.door_state = door_q;
            has_res   = 1'b1;
            hdr_stage = '0;
            pay_cnt   = 0;
         end
      end
   endtask

   // One request transaction; records the expected frame result if any
   task automatic send_item(input logic f, input logic [7:0] rx, input logic [7:0] dv,
                            input bit use_typed, input frame_res_type typed);
      int            gap;
      bit            rdy;
      bit            has_res;
      frame_res_type res;
      gap = tx_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {dv, rx};
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      track_reader_item(f, rx, dv, has_res, res);
      if (use_typed) pending_frames.push_back(typed);
      else if (has_res) pending_frames.push_back(res);
      n_items++;
      if (f == FUNC_DOOR) n_doors++;
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_item(FUNC_BYTE, rx, 8'($urandom), 1'b0, '0);
   endtask

   task automatic send_door(input logic [7:0] dv);
      send_item(FUNC_DOOR, 8'($urandom), dv, 1'b0, '0);
   endtask

   // Header plus payload carrying the given id, sometimes a door write inside
   task automatic send_frame(input logic [63:0] id);
      logic [7:0] pay [PAY_LEN];
      int         door_at;
      for (int j = 0; j < PAY_LEN; j++) begin
         // payload byte j holds id byte 6 - (j & 6) + (j & 1)
         if (j < ID_BYTES) pay[j] = id[63 - 8 * ((6 - (j & 6)) + (j & 1)) -: 8];
         else pay[j] = 8'($urandom);
      end
      door_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, HDR_LEN + PAY_LEN - 1) : -1;
      for (int i = 0; i < HDR_LEN + PAY_LEN; i++) begin
         if (i == door_at) send_door(8'($urandom));
         send_byte(i < HDR_LEN ? HDR_SEQ[39 - 8 * i -: 8] : pay[i - HDR_LEN]);
      end
   endtask

   // Limit write once the block has drained
   task automatic set_limit(input logic [3:0] v);
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_q = (v >= TBL_DEPTH) ? 4'(TBL_DEPTH) : v;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      errors++;
      if (errors <= MAX_REPORTS) $display("tb: %s mismatch, expected %h, got %h", what, want, got);
   endtask

   // Result side: random stalls per transaction
   initial begin : rsp_side
      int stall;
      bit hs;
      @(negedge reset);
      forever begin
         stall = rx_idle_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            hs = rsp_tvalid;
            @(posedge clock);
         end while (!hs);
      end
   end

   // Result check, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin : rsp_check
      frame_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            note_mismatch("unexpected result, card_id", '0, rsp_tdata[63:0]);
         end else begin
            want = pending_frames.pop_front();
            n_results++;
            if (want.known) n_known++;
            else if (want.enrolled) n_enrolled++;
            else n_refused++;
            if (rsp_tdata[63:0] != want.card_id)
               note_mismatch("card_id", want.card_id, rsp_tdata[63:0]);
            if (rsp_tuser[0] != want.known)
               note_mismatch("known", 64'(want.known), 64'(rsp_tuser[0]));
            if (rsp_tuser[1] != want.enrolled)
               note_mismatch("enrolled", 64'(want.enrolled), 64'(rsp_tuser[1]));
            if (rsp_tdata[71:64] != want.door_state)
               note_mismatch("door_state", 64'(want.door_state), 64'(rsp_tdata[71:64]));
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      logic [63:0] id_pool [12];
      int          load;
      int          pick;
      int          len;
      logic [7:0]  bad;
      hdr_stage = '0;
      pay_cnt   = 0;
      n_ids     = 0;
      door_q    = '0;
      limit_q   = MAX_ENT_RST;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 2; k < 12; k++) id_pool[k] = {$urandom, $urandom};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Scripted sequence
      foreach (script[i])
         send_item(script[i][16], script[i][7:0], script[i][15:8], script[i][17], SCRIPT_RES);

      // Random phases, one limit setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) set_limit(phase_limit[p]);
         load = 0;
         while (load < PHASE_LOAD) begin
            if ($urandom_range(0, 15) == 0) tx_idle_on = !tx_idle_on;
            if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_frame($urandom_range(0, 9) < 7 ? id_pool[$urandom_range(0, 11)]
                                                   : {$urandom, $urandom});
               load += HDR_LEN + PAY_LEN;
            end else if (pick < 77) begin
               // header cut short by a wrong byte, often a fresh 0A
               len = $urandom_range(1, HDR_LEN - 1);
               for (int i = 0; i < len; i++) send_byte(HDR_SEQ[39 - 8 * i -: 8]);
               bad = $urandom_range(0, 1) ? 8'h0A : 8'($urandom);
               if (bad == HDR_SEQ[39 - 8 * len -: 8]) bad = ~bad;
               send_byte(bad);
            end else if (pick < 87) begin
               send_door(8'($urandom));
               load++;
            end else begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
         end
      end

      // Drain
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("tb: %0d transactions sent, %0d door writes, %0d mismatches", n_items, n_doors,
               errors);
      $display("tb: %0d frames checked: %0d known, %0d enrolled, %0d refused; %0d ids stored",
               n_results, n_known, n_enrolled, n_refused, n_ids);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400_000;
      $display("tb: failure");
      $finish;
   end

endmodule
